>>> rtl/core/stt_pkg.sv
// shared types, codes and helpers for the supervisor timeout tick planner
`timescale 1ns / 1ps

package stt_pkg;

    localparam int NOW_W     = 48;
    localparam int DUE_W     = 49;
    localparam int PROD_W    = 41;
    localparam int WAIT_W    = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int MS_PER_S  = 1000;

    localparam int DEF_QUEUE_DEPTH  = 4;
    localparam int DEF_RESULT_DEPTH = 8;

    localparam logic [WAIT_W-1:0] BUSY_WAIT_MS = WAIT_W'(10);
    localparam logic [WAIT_W-1:0] MIN_WAIT_MS  = WAIT_W'(1);

    localparam logic [CFG_W-1:0] IDLE_WAIT_RESET     = CFG_W'(1000);
    localparam logic [CFG_W-1:0] DRAINING_WAIT_RESET = CFG_W'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAINING_WAIT = 1'b1;

    // process flag bit positions
    localparam int FLG_HAS_PROCESS = 0;
    localparam int FLG_RESTART     = 1;
    localparam int FLG_TERMINATING = 2;
    localparam int FLG_DRAINING    = 3;
    localparam int FLG_STARTING    = 4;
    localparam int FLG_ONLINE      = 5;
    localparam int FLG_BUSY        = 6;

    // result types
    localparam logic [1:0] RES_RESTART = 2'd0;
    localparam logic [1:0] RES_TIMEOUT = 2'd1;
    localparam logic [1:0] RES_SUMMARY = 2'd2;

    // failure actions on input
    localparam logic [1:0] FA_SKIP    = 2'd0;
    localparam logic [1:0] FA_RESTART = 2'd1;
    localparam logic [1:0] FA_REBOOT  = 2'd2;

    // timeout actions on output
    localparam logic [1:0] ACT_IGNORE  = 2'd0;
    localparam logic [1:0] ACT_ACCEPT  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_REBOOT  = 2'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BEAT  = 1'b1;

    // item classes between front and back
    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_RESTART = 2'd1;
    localparam logic [1:0] CLS_TERM    = 2'd2;
    localparam logic [1:0] CLS_TIMER   = 2'd3;

    typedef struct packed {
        logic [47:0] now_ms;
        logic [6:0]  process_flags;
        logic [47:0] pending_due_ms;
        logic [47:0] launched_ms;
        logic signed [31:0] start_limit_s;
        logic [47:0] last_beat_ms;
        logic signed [31:0] beat_timeout_s;
        logic [47:0] beat_action_due_ms;
        logic [15:0] proc_index;
        logic [31:0] proc_generation;
        logic [1:0]  on_fail_act;
        logic        last_process;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_type;
        logic [15:0] out_index;
        logic [31:0] out_generation;
        logic        timeout_kind;
        logic [1:0]  timeout_action;
        logic [30:0] tick_wait_ms;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       cls;
        logic [DUE_W-1:0] due;
        logic [NOW_W-1:0] now;
        logic [15:0]      idx;
        logic [31:0]      gen;
        logic             kind;
        logic [1:0]       action;
        logic             drain;
        logic             busy;
        logic             last;
    } cls_item_t;

    // wait register clamped to at least one
    function automatic logic [WAIT_W-1:0] clamp_wait(input logic [CFG_W-1:0] v);
        logic [WAIT_W-1:0] r;
        if (v[CFG_W-1] || (v == '0))
        begin
            r = MIN_WAIT_MS;
        end
        else
        begin
            r = v[WAIT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/stt_fifo.sv
// small first-in first-out queue between the front and the back
`timescale 1ns / 1ps

module stt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/stt_front.sv
// front: takes process items, scales timeouts and classifies each item
`timescale 1ns / 1ps

module stt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  stt_pkg::in_item_t   item,
    output logic                q_wr,
    output stt_pkg::cls_item_t  q_data,
    input  logic                q_full
);
    import stt_pkg::*;

    logic              f1_valid_reg, f1_valid_next;
    in_item_t          f1_item_reg;
    logic [PROD_W-1:0] start_prod_reg, beat_prod_reg;
    logic              start_en_reg, beat_en_reg;
    logic              accept;

    logic [DUE_W-1:0]  start_due, beat_sum, beat_due;
    logic [6:0]        flags;

    assign full   = f1_valid_reg && q_full;
    assign accept = push && !full;
    assign q_wr   = f1_valid_reg && !q_full;

    assign f1_valid_next = accept || (f1_valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    // timeouts in seconds scaled to ms here, added on the next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_item_reg    <= item;
            start_prod_reg <= PROD_W'(item.start_limit_s[30:0]) * PROD_W'(MS_PER_S);
            beat_prod_reg  <= PROD_W'(item.beat_timeout_s[30:0]) * PROD_W'(MS_PER_S);
            start_en_reg   <= !item.start_limit_s[31];
            beat_en_reg    <= !item.beat_timeout_s[31] && (item.beat_timeout_s != '0);
        end
    end

    assign flags     = f1_item_reg.process_flags;
    assign start_due = DUE_W'(f1_item_reg.launched_ms) + DUE_W'(start_prod_reg);
    assign beat_sum  = DUE_W'(f1_item_reg.last_beat_ms) + DUE_W'(beat_prod_reg);
    assign beat_due  = (DUE_W'(f1_item_reg.beat_action_due_ms) > beat_sum)
                     ? DUE_W'(f1_item_reg.beat_action_due_ms) : beat_sum;

    always_comb
    begin
        q_data        = '0;
        q_data.now    = f1_item_reg.now_ms;
        q_data.idx    = f1_item_reg.proc_index;
        q_data.gen    = f1_item_reg.proc_generation;
        q_data.busy   = flags[FLG_BUSY];
        q_data.last   = f1_item_reg.last_process;
        q_data.cls    = CLS_NONE;
        q_data.due    = DUE_W'(f1_item_reg.pending_due_ms);
        q_data.kind   = KIND_START;

        priority if (!flags[FLG_HAS_PROCESS])
        begin
            if (flags[FLG_RESTART])
            begin
                q_data.cls = CLS_RESTART;
            end
        end
        else if (flags[FLG_TERMINATING])
        begin
            q_data.cls   = CLS_TERM;
            q_data.drain = flags[FLG_DRAINING];
            // no termination due: all ones never lowers the running minimum
            if (f1_item_reg.pending_due_ms == '0)
            begin
                q_data.due = '1;
            end
        end
        else if (flags[FLG_STARTING] && start_en_reg)
        begin
            q_data.cls = CLS_TIMER;
            q_data.due = start_due;
        end
        else if (flags[FLG_ONLINE] && beat_en_reg)
        begin
            q_data.cls  = CLS_TIMER;
            q_data.due  = beat_due;
            q_data.kind = KIND_BEAT;
        end
        else
        begin
            // running process with no armed timer
            q_data.cls = CLS_NONE;
        end

        unique case (f1_item_reg.on_fail_act)
            FA_SKIP:    q_data.action = (q_data.kind == KIND_START) ? ACT_ACCEPT : ACT_IGNORE;
            FA_RESTART: q_data.action = ACT_RESTART;
            FA_REBOOT:  q_data.action = ACT_REBOOT;
            default:    q_data.action = ACT_IGNORE;
        endcase
    end

endmodule

>>> rtl/core/stt_back.sv
// back: checks due times, keeps the tick state and buffers the results
`timescale 1ns / 1ps

module stt_back #(
    parameter int RESULT_DEPTH = stt_pkg::DEF_RESULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  stt_pkg::cls_item_t                  q_data,
    output logic                                q_rd,
    input  logic                                cfg_valid,
    input  logic [stt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stt_pkg::CFG_W-1:0]           cfg_data,
    output logic                                empty,
    input  logic                                pop,
    output stt_pkg::out_item_t                  result
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(RESULT_DEPTH);
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    logic [CFG_W-1:0]  idle_wait_reg, draining_wait_reg;
    logic [WAIT_W-1:0] dflt_wait;

    // tick state
    logic              tick_open_reg;
    logic              event_reg, drain_reg;
    logic [DUE_W-1:0]  earliest_reg;

    // summary stage
    logic              sum_valid_reg;
    logic [DUE_W-1:0]  sum_earliest_reg;
    logic [NOW_W-1:0]  sum_now_reg;
    logic              sum_event_reg, sum_drain_reg, sum_busy_reg;

    // result buffer
    out_item_t         ob [RESULT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_inc, wr_ptr_inc2, rd_ptr_inc;
    logic [CNT_W-1:0]  ob_count_reg, ob_count_next;

    logic              adv, is_due, fire, fold, ev_push, pop_ok;
    logic              base_event, base_drain;
    logic [DUE_W-1:0]  now_ext, base_earliest, earliest_new;
    logic              event_new, drain_new;
    out_item_t         ev_item, sum_item;
    logic [DUE_W-1:0]  gap;
    logic [WAIT_W-1:0] wait_ms;

    assign dflt_wait = clamp_wait(idle_wait_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_wait_reg     <= IDLE_WAIT_RESET;
            draining_wait_reg <= DRAINING_WAIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDLE_WAIT:     idle_wait_reg     <= cfg_data;
                CFG_DRAINING_WAIT: draining_wait_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // leave room for this item's event plus the summary still to come
    assign adv  = !q_empty && (ob_count_reg <= CNT_W'(RESULT_DEPTH - 3));
    assign q_rd = adv;

    assign now_ext       = DUE_W'(q_data.now);
    assign base_earliest = tick_open_reg ? earliest_reg : now_ext + DUE_W'(dflt_wait);
    assign base_event    = tick_open_reg && event_reg;
    assign base_drain    = tick_open_reg && drain_reg;

    assign is_due = (q_data.due <= now_ext);
    assign fire   = ((q_data.cls == CLS_RESTART) || (q_data.cls == CLS_TIMER)) && is_due;
    assign fold   = (((q_data.cls == CLS_RESTART) || (q_data.cls == CLS_TIMER)) && !is_due)
                 || (q_data.cls == CLS_TERM);

    assign earliest_new = (fold && (q_data.due < base_earliest)) ? q_data.due : base_earliest;
    assign event_new    = base_event || fire;
    assign drain_new    = base_drain || ((q_data.cls == CLS_TERM) && q_data.drain);
    assign ev_push      = adv && fire;

    always_comb
    begin
        ev_item           = '0;
        ev_item.out_index = q_data.idx;
        if (q_data.cls == CLS_RESTART)
        begin
            ev_item.result_type = RES_RESTART;
        end
        else
        begin
            ev_item.result_type    = RES_TIMEOUT;
            ev_item.out_generation = q_data.gen;
            ev_item.timeout_kind   = q_data.kind;
            ev_item.timeout_action = q_data.action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_open_reg <= 1'b0;
            event_reg     <= 1'b0;
            drain_reg     <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= adv && q_data.last;
            if (adv)
            begin
                tick_open_reg <= !q_data.last;
                event_reg     <= event_new;
                drain_reg     <= drain_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            earliest_reg     <= earliest_new;
            sum_earliest_reg <= earliest_new;
            sum_now_reg      <= q_data.now;
            sum_event_reg    <= event_new;
            sum_drain_reg    <= drain_new;
            sum_busy_reg     <= q_data.busy;
        end
    end

    // summary wait from the closed tick
    assign gap = sum_earliest_reg - DUE_W'(sum_now_reg);

    always_comb
    begin
        priority if (sum_event_reg)
        begin
            wait_ms = MIN_WAIT_MS;
        end
        else if (sum_busy_reg)
        begin
            wait_ms = BUSY_WAIT_MS;
        end
        else if (sum_drain_reg)
        begin
            wait_ms = clamp_wait(draining_wait_reg);
        end
        else if (sum_earliest_reg <= DUE_W'(sum_now_reg))
        begin
            wait_ms = MIN_WAIT_MS;
        end
        else if (gap < DUE_W'(dflt_wait))
        begin
            wait_ms = gap[WAIT_W-1:0];
        end
        else
        begin
            wait_ms = dflt_wait;
        end
    end

    always_comb
    begin
        sum_item              = '0;
        sum_item.result_type  = RES_SUMMARY;
        sum_item.tick_wait_ms = wait_ms;
        sum_item.last_result  = 1'b1;
    end

    // the summary is older than any event pushed in the same cycle
    assign pop_ok = pop && !empty;
    assign empty  = (ob_count_reg == '0);
    assign result = ob[rd_ptr_reg];

    assign wr_ptr_inc  = (wr_ptr_reg == PTR_W'(RESULT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_ptr_inc2 = (wr_ptr_inc == PTR_W'(RESULT_DEPTH - 1)) ? '0 : wr_ptr_inc + 1'b1;
    assign rd_ptr_inc  = (rd_ptr_reg == PTR_W'(RESULT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign ob_count_next = ob_count_reg + CNT_W'(sum_valid_reg) + CNT_W'(ev_push)
                         - CNT_W'(pop_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            ob_count_reg <= '0;
        end
        else
        begin
            if (sum_valid_reg && ev_push)
            begin
                wr_ptr_reg <= wr_ptr_inc2;
            end
            else if (sum_valid_reg || ev_push)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            ob_count_reg <= ob_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid_reg)
        begin
            ob[wr_ptr_reg] <= sum_item;
        end
        if (ev_push)
        begin
            ob[sum_valid_reg ? wr_ptr_inc : wr_ptr_reg] <= ev_item;
        end
    end

`ifndef ASSERT_OFF
    a_ob_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ob_count_reg <= CNT_W'(RESULT_DEPTH))
        else $error("result buffer overflow");

    a_sum_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && q_data.last) |=> sum_valid_reg)
        else $error("closing item without summary");

    a_last_on_summary: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.last_result == (result.result_type == RES_SUMMARY)))
        else $error("last_result does not match summary type");

    a_tick_closed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg |-> !tick_open_reg)
        else $error("tick still open after summary");
`endif

endmodule

>>> rtl/core/supervisor_timeout_tick_planner.sv
// top level: process timeout tick planner with decoupled front and back
`timescale 1ns / 1ps
// event path: front register, queue, result buffer; a summary also passes the summary stage
// throughput: one item per cycle unless stalled, set by front scaling and the back due check
// an item with an event and a summary needs two pops, so such items are held back by the pops
// the back holds items while more than RESULT_DEPTH-3 results wait to be popped
// reset clears the queues and the tick state, default wait 1000 ms and draining wait 100 ms

module supervisor_timeout_tick_planner #(
    parameter int QUEUE_DEPTH  = stt_pkg::DEF_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = stt_pkg::DEF_RESULT_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  stt_pkg::in_item_t             item,
    output logic                          empty,
    input  logic                          pop,
    output stt_pkg::out_item_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stt_pkg::CFG_W-1:0]     cfg_data
);
    import stt_pkg::*;

    logic      q_wr, q_full, q_rd, q_empty;
    cls_item_t q_wr_data, q_rd_data;

    assign cfg_ready = 1'b1;

    stt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_wr   (q_wr),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    stt_fifo #(
        .WIDTH ($bits(cls_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    stt_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_rd      (q_rd),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
